// ===== sv/key_polynomial_bucket_hash_assert.svh =====
// Assertion macros for the key polynomial bucket hash block.
// Used by the top level only; needs a clock named aclk and a reset named aresetn.
`ifndef KEY_POLYNOMIAL_BUCKET_HASH_ASSERT_SVH
`define KEY_POLYNOMIAL_BUCKET_HASH_ASSERT_SVH

// Implication checked on every clock edge outside reset
`define KPBH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Implication checked on every clock edge, reset included
`define KPBH_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== sv/kpbh_pkg.sv =====
// Shared types and constants for the key polynomial bucket hash block.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps

package kpbh_pkg;

    // Key length in bytes and byte counter width
    localparam int KEY_BYTES = 16;
    localparam int CNT_W     = 5;

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int HASH_W   = 32;
    localparam int BUCKET_W = 31;
    localparam int OUT_W    = 64;

    // Restoring divider: one quotient bit per cycle
    localparam int DIV_STEPS  = HASH_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HASH_FACTOR  = 1'b0,
        CFG_TABLE_LENGTH = 1'b1
    } cfg_idx_t;

    localparam logic [HASH_W-1:0]   FACTOR_RESET = 32'd17;
    localparam logic [BUCKET_W-1:0] TLEN_RESET   = 31'd1024;

    // Controller to datapath commands
    typedef struct packed {
        logic mul;       // latch byte, form hash * factor
        logic add;       // add byte into running hash
        logic last;      // with add: last byte, start division, clear hash
        logic div_step;  // one restoring division step
        logic out_load;  // load result into output register
    } kpbh_cmd_t;

    // Datapath status seen by the top level
    typedef struct packed {
        logic [BUCKET_W-1:0] table_length;
    } kpbh_stat_t;

endpackage

// ===== sv/kpbh_ctrl.sv =====
// Controller state machine for the key polynomial bucket hash block.
// Depends on kpbh_pkg; drives commands into kpbh_dp.
`timescale 1ns / 1ps

module kpbh_ctrl
    import kpbh_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output kpbh_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               last_reg;
    logic               out_valid_reg;
    logic               in_accept;
    logic               load_ok;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign load_ok   = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    // Commands decoded from state
    always_comb begin
        cmd          = '0;
        cmd.mul      = in_accept;
        cmd.add      = (state_reg == ST_ADD);
        cmd.last     = (state_reg == ST_ADD) && last_reg;
        cmd.div_step = (state_reg == ST_DIV);
        cmd.out_load = (state_reg == ST_DONE) && load_ok;
    end

    // State, counters and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            // New result takes priority over the drain of the old one
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_accept) begin
                        last_reg  <= (count_reg == CNT_W'(KEY_BYTES - 1));
                        state_reg <= ST_ADD;
                    end
                end
                ST_ADD: begin
                    if (last_reg) begin
                        count_reg <= '0;
                        step_reg  <= '0;
                        state_reg <= ST_DIV;
                    end else begin
                        count_reg <= count_reg + 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_DIV: begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(DIV_STEPS - 1))
                        state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (load_ok)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== sv/kpbh_dp.sv =====
// Datapath for the key polynomial bucket hash block: config registers,
// multiply-add hash, restoring divider and result register. Depends on kpbh_pkg.
`timescale 1ns / 1ps

module kpbh_dp
    import kpbh_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [BYTE_W-1:0]     key_byte,
    input  kpbh_cmd_t             cmd,
    output logic [OUT_W-1:0]      out_data,
    output kpbh_stat_t            stat
);

    logic [HASH_W-1:0]   factor_reg;
    logic [BUCKET_W-1:0] tlen_reg;
    logic [HASH_W-1:0]   hash_reg;
    logic [HASH_W-1:0]   prod_reg;
    logic [BYTE_W-1:0]   byte_reg;
    logic [HASH_W-1:0]   hash_res_reg;
    logic [HASH_W-1:0]   dvd_reg;
    logic [BUCKET_W-1:0] rem_reg;
    logic [HASH_W-1:0]   out_hash_reg;
    logic [BUCKET_W-1:0] out_bucket_reg;
    logic [HASH_W-1:0]   hash_sum;
    logic [HASH_W-1:0]   rem_shift;
    logic [HASH_W-1:0]   rem_sub;
    logic                rem_ge;
    logic [BUCKET_W-1:0] rem_next;

    assign stat.table_length = tlen_reg;
    assign out_data = {1'b0, out_bucket_reg, out_hash_reg};

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            factor_reg <= FACTOR_RESET;
            tlen_reg   <= TLEN_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_HASH_FACTOR:  factor_reg <= cfg_wdata;
                CFG_TABLE_LENGTH: tlen_reg   <= cfg_wdata[BUCKET_W-1:0];
                default: ;
            endcase
        end
    end

    // Running hash: register the product, then add the byte in the next cycle
    assign hash_sum = prod_reg + HASH_W'(byte_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg <= '0;
        end else if (cmd.add) begin
            hash_reg <= cmd.last ? '0 : hash_sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            prod_reg <= hash_reg * factor_reg;
            byte_reg <= key_byte;
        end
    end

    // Restoring division step; remainder stays below a nonzero table length that is held during the division
    assign rem_shift = {rem_reg, dvd_reg[HASH_W-1]};
    assign rem_sub   = rem_shift - HASH_W'(tlen_reg);
    assign rem_ge    = (rem_shift >= HASH_W'(tlen_reg));
    assign rem_next  = rem_ge ? rem_sub[BUCKET_W-1:0] : rem_shift[BUCKET_W-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.last) begin
            hash_res_reg <= hash_sum;
            dvd_reg      <= hash_sum;
            rem_reg      <= '0;
        end else if (cmd.div_step) begin
            dvd_reg <= {dvd_reg[HASH_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    // Result register; zero table length gives bucket zero
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_hash_reg   <= hash_res_reg;
            out_bucket_reg <= (tlen_reg == '0) ? '0 : rem_reg;
        end
    end

endmodule

// ===== sv/key_polynomial_bucket_hash.sv =====
// A key byte is accepted in ST_IDLE, which registers hash * factor, and is added
// in ST_ADD, where s_tready is low, so bytes are never accepted back to back.
// After the last byte of a key the 32-step bit-serial modulo unit runs; the result
// is loaded once the output is free, and no new byte is accepted until then.
// Reset: synchronous active-low aresetn clears hash, counts and valid flags
// and restores hash_factor to 17 and table_length to 1024.
`timescale 1ns / 1ps

`include "key_polynomial_bucket_hash_assert.svh"

module key_polynomial_bucket_hash
    import kpbh_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // Input word stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] key_byte
    // Result word stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_W-1:0]      m_tdata    // [31:0] hash_value, [62:32] bucket_index
);

    kpbh_cmd_t  cmd;
    kpbh_stat_t stat;

    kpbh_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd)
    );

    kpbh_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .key_byte  (s_tdata),
        .cmd       (cmd),
        .out_data  (m_tdata),
        .stat      (stat)
    );

    // An accepted word is followed by the add state, so no back-to-back accept
    `KPBH_ASSERT(a_no_b2b, (s_tvalid && s_tready) |=> !s_tready, "input accepted back to back")
    // A new result appears only from a result load
    `KPBH_ASSERT(a_rise_load, $rose(m_tvalid) |-> $past(cmd.out_load), "valid rose without load")
    // Bucket index stays below a nonzero table length
    `KPBH_ASSERT(a_bucket_range,
        (m_tvalid && stat.table_length != '0) |-> (m_tdata[62:32] < stat.table_length),
        "bucket index out of range")

endmodule

// ===== tb/sv/kpbh_result_checker.sv =====
// Checker for the key polynomial bucket hash block: predicts each key's hash and bucket.
// It watches the config port and both word streams. It depends on kpbh_pkg.
`timescale 1ns / 1ps

module kpbh_result_checker
    import kpbh_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] key_byte
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_W-1:0]      m_tdata,   // [31:0] hash_value, [62:32] bucket_index
    output int                    fail_count,
    output int                    pending
);

    typedef struct packed {
        logic [HASH_W-1:0]   hash;
        logic [BUCKET_W-1:0] bucket;
    } key_result_t;

    // Shadow registers and partial key state
    logic [HASH_W-1:0]   hash_factor;
    logic [BUCKET_W-1:0] table_length;
    logic [HASH_W-1:0]   key_hash;
    int                  key_count;
    key_result_t         key_result_q[$];

    // Final hash of a key and its bucket; a zero table length maps to bucket 0
    function automatic key_result_t bucket_key(input logic [HASH_W-1:0] h,
                                               input logic [BUCKET_W-1:0] tlen);
        key_result_t r;
        r.hash   = h;
        r.bucket = (tlen == '0) ? '0 : BUCKET_W'(h % tlen);
        return r;
    endfunction

    always @(posedge aclk) begin
        key_result_t       got;
        key_result_t       want;
        logic [HASH_W-1:0] next_hash;
        if (!aresetn) begin
            hash_factor  = FACTOR_RESET;
            table_length = TLEN_RESET;
            key_hash     = '0;
            key_count    = 0;
            fail_count   = 0;
            key_result_q.delete();
        end else begin
            // Register writes
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_HASH_FACTOR:  hash_factor  = cfg_wdata[HASH_W-1:0];
                    CFG_TABLE_LENGTH: table_length = cfg_wdata[BUCKET_W-1:0];
                    default: ;
                endcase
            end

            // Absorb an accepted key byte
            if (s_tvalid && s_tready) begin
                next_hash = key_hash * hash_factor + HASH_W'(s_tdata);
                if (key_count == KEY_BYTES - 1) begin
                    key_result_q.push_back(bucket_key(next_hash, table_length));
                    key_hash  = '0;
                    key_count = 0;
                end else begin
                    key_hash  = next_hash;
                    key_count = key_count + 1;
                end
            end

            // Compare an accepted result word with the oldest prediction
            if (m_tvalid && m_tready) begin
                got.hash   = m_tdata[HASH_W-1:0];
                got.bucket = m_tdata[HASH_W +: BUCKET_W];
                if (key_result_q.size() == 0) begin
                    $error("unexpected result word: hash_value %h, bucket_index %h",
                           got.hash, got.bucket);
                    fail_count = fail_count + 1;
                end else begin
                    want = key_result_q.pop_front();
                    if (got.hash !== want.hash) begin
                        $error("hash_value mismatch: expected %h, got %h",
                               want.hash, got.hash);
                        fail_count = fail_count + 1;
                    end
                    if (got.bucket !== want.bucket) begin
                        $error("bucket_index mismatch: expected %h, got %h",
                               want.bucket, got.bucket);
                        fail_count = fail_count + 1;
                    end
                end
            end
        end
        pending = key_result_q.size();
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// Top of the key polynomial bucket hash testbench: clock, reset, key byte stimulus,
// register settings and the verdict. It depends on kpbh_pkg, the block and kpbh_result_checker.
`timescale 1ns / 1ps

module tb_top;
    import kpbh_pkg::*;

    typedef enum int {RX_ALWAYS, RX_HALF, RX_SPARSE, RX_ALTERNATE} rx_mode_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;   // [7:0] key_byte
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_W-1:0]      m_tdata;   // [31:0] hash_value, [62:32] bucket_index

    int          fail_count;
    int          pending;
    int unsigned burst_left;
    int          bytes_sent;
    logic        hold_req;
    logic        hold_done;

    key_polynomial_bucket_hash u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    kpbh_result_checker u_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 8 ns clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Run limit
    initial begin
        #4_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Byte value biased toward the extremes
    function automatic logic [7:0] pick_key_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Offer one key byte; bursts of random length with random gaps between
    task automatic send_byte(input logic [7:0] key_byte);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        s_tvalid = 1'b1;
        s_tdata  = key_byte;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left = burst_left - 1;
        @(negedge aclk);
    endtask

    // Stop offering, let every result drain and the datapath settle
    task automatic quiesce();
        s_tvalid   = 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        @(negedge aclk);
    endtask

    // Receiver: own pattern of stalls, plus one long hold-off on request
    initial begin
        rx_mode_t    mode;
        int unsigned span_left;
        m_tready  = 1'b0;
        hold_done = 1'b0;
        mode      = RX_ALWAYS;
        span_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                m_tready = 1'b0;
                repeat (600) @(negedge aclk);
                hold_done = 1'b1;
            end else begin
                if (span_left == 0) begin
                    mode      = rx_mode_t'($urandom_range(0, 3));
                    span_left = $urandom_range(32, 256);
                end
                case (mode)
                    RX_ALWAYS:    m_tready = 1'b1;
                    RX_HALF:      m_tready = 1'($urandom_range(0, 1));
                    RX_SPARSE:    m_tready = ($urandom_range(0, 3) == 0);
                    RX_ALTERNATE: m_tready = span_left[1];
                    default:      m_tready = 1'b1;
                endcase
                span_left = span_left - 1;
            end
        end
    end

    // Stimulus and verdict
    initial begin
        logic [CFG_DATA_W-1:0] factor_word;
        logic [CFG_DATA_W-1:0] tlen_word;
        int                    phase;
        int                    n_bytes;
        aresetn    = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_index  = CFG_HASH_FACTOR;
        cfg_wdata  = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        hold_req   = 1'b0;
        burst_left = 0;
        bytes_sent = 0;
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;

        // Reset settings: one key of all-ones then all-zeros bytes
        for (int i = 0; i < KEY_BYTES; i++) send_byte((i < KEY_BYTES / 2) ? 8'hFF : 8'h00);

        // Zero table length, and a factor change halfway through the key
        quiesce();
        write_reg(CFG_TABLE_LENGTH, '0);
        for (int i = 0; i < KEY_BYTES / 2; i++) send_byte(8'h80 >> i);
        quiesce();
        write_reg(CFG_HASH_FACTOR, 32'hFFFF_FFFF);
        for (int i = 0; i < KEY_BYTES / 2; i++) send_byte(~(8'h80 >> i));
        bytes_sent = 2 * KEY_BYTES;

        // Random phases; most end inside a key, so later writes land mid-key
        phase = 0;
        while (bytes_sent < 1250) begin
            case (phase)
                0: begin factor_word = 32'h0100_0193; tlen_word = 32'd1000;       end
                1: begin factor_word = 32'h0000_0000; tlen_word = 32'h7FFF_FFFF;  end
                2: begin factor_word = 32'h0000_0001; tlen_word = 32'd1;          end
                3: begin factor_word = 32'hFFFF_FFFF; tlen_word = 32'd2;          end
                4: begin factor_word = 32'd31;        tlen_word = 32'd0;          end
                // top bit of the write data lies beyond the 31-bit register
                5: begin factor_word = 32'd33;        tlen_word = 32'h8000_0065;  end
                default: begin
                    case ($urandom_range(0, 5))
                        0:       factor_word = 32'h0000_0000;
                        1:       factor_word = 32'h0000_0001;
                        2:       factor_word = 32'hFFFF_FFFF;
                        default: factor_word = $urandom;
                    endcase
                    case ($urandom_range(0, 2))
                        0:       tlen_word = $urandom_range(1, 64);
                        1:       tlen_word = $urandom & 32'h7FFF_FFFF;
                        default: tlen_word = $urandom;
                    endcase
                end
            endcase
            quiesce();
            write_reg(CFG_HASH_FACTOR, factor_word);
            write_reg(CFG_TABLE_LENGTH, tlen_word);
            // first phase: long receiver hold-off while bytes keep being offered
            if (phase == 0) hold_req = 1'b1;
            n_bytes = (phase == 0) ? 256 : $urandom_range(40, 200);
            for (int i = 0; i < n_bytes; i++) send_byte(pick_key_byte());
            bytes_sent = bytes_sent + n_bytes;
            phase = phase + 1;
        end

        // Drain, then allow for the block's latency
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/kpbh_pkg.sv
sv/kpbh_ctrl.sv
sv/kpbh_dp.sv
sv/key_polynomial_bucket_hash.sv
tb/sv/kpbh_result_checker.sv
tb/sv/tb_top.sv
